// ===== rtl/md5_pkg.sv =====
// ----------------------------------------------------------------------------
// md5_pkg
// Shared constants, types and step tables for the MD5 digest engine.
// ----------------------------------------------------------------------------
package md5_pkg;

    localparam int unsigned BlockBytes = 64;
    localparam int unsigned WordCount  = 16;
    localparam int unsigned StepCount  = 64;
    localparam int unsigned CountWidth = 61;
    localparam int unsigned PadLimit   = 56;

    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hEFCDAB89;
    localparam logic [31:0] INIT_C = 32'h98BADCFE;
    localparam logic [31:0] INIT_D = 32'h10325476;

    typedef struct packed {
        logic       op;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [1:0]  word_index;
        logic        last_word;
    } t_out_item;

    // Request from the controller to the round core
    typedef struct packed {
        logic start;
    } t_core_req;

    // Status from the round core back to the controller
    typedef struct packed {
        logic busy;
        logic done;
    } t_core_sts;

    function automatic logic [31:0] round_const(input logic [5:0] i);
        logic [31:0] k;
        begin
            case (i)
                6'd0:  k = 32'hd76aa478; 6'd1:  k = 32'he8c7b756;
                6'd2:  k = 32'h242070db; 6'd3:  k = 32'hc1bdceee;
                6'd4:  k = 32'hf57c0faf; 6'd5:  k = 32'h4787c62a;
                6'd6:  k = 32'ha8304613; 6'd7:  k = 32'hfd469501;
                6'd8:  k = 32'h698098d8; 6'd9:  k = 32'h8b44f7af;
                6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
                6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
                6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
                6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
                6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
                6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
                6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
                6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
                6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
                6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
                6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
                6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
                6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
                6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
                6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
                6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
                6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
                6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
                6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
                6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
                6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
                6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
                6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
                6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
                6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
                6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
                6'd62: k = 32'h2ad7d2bb; 6'd63: k = 32'heb86d391;
                default: k = 32'h0;
            endcase
            return k;
        end
    endfunction

    function automatic logic [4:0] rot_amount(input logic [5:0] i);
        logic [4:0] s;
        begin
            case ({i[5:4], i[1:0]})
                4'd0:  s = 5'd7;  4'd1:  s = 5'd12; 4'd2:  s = 5'd17; 4'd3:  s = 5'd22;
                4'd4:  s = 5'd5;  4'd5:  s = 5'd9;  4'd6:  s = 5'd14; 4'd7:  s = 5'd20;
                4'd8:  s = 5'd4;  4'd9:  s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
                4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; 4'd15: s = 5'd21;
                default: s = 5'd0;
            endcase
            return s;
        end
    endfunction

    // Message word index used at a step
    function automatic logic [3:0] msg_index(input logic [5:0] i);
        logic [3:0] g;
        begin
            case (i[5:4])
                2'd0:    g = i[3:0];
                2'd1:    g = 4'(5'd1 + {i[3:0], 2'b00} + {1'b0, i[3:0]});
                2'd2:    g = 4'(5'd5 + {i[3:0], 1'b0} + {1'b0, i[3:0]});
                default: g = 4'({i[3:0], 3'b000} - {3'b000, i[3:0]});
            endcase
            return g;
        end
    endfunction

endpackage

// ===== rtl/md5_stream_if.sv =====
// ----------------------------------------------------------------------------
// md5_stream_if
// Valid/ready channel carrying one payload item per request.
// ----------------------------------------------------------------------------
interface md5_stream_if #(
    parameter int unsigned Width = 9
);
    logic             valid;
    logic             ready;
    logic [Width-1:0] payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/md5_core.sv =====
// ----------------------------------------------------------------------------
// md5_core
// Block buffer memory, chaining memory and the single-step MD5 round unit.
// ----------------------------------------------------------------------------
module md5_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // byte write port into the block buffer
    input  logic              i_wr_en,
    input  logic [5:0]        i_wr_addr,
    input  logic [7:0]        i_wr_byte,
    input  md5_pkg::t_core_req i_req,
    input  logic              i_chain_init,
    input  logic [1:0]        i_rd_idx,
    output logic [31:0]       o_chain_word,
    output md5_pkg::t_core_sts o_sts
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOAD  = 3'd1;
    localparam logic [2:0] S_STEP  = 3'd2;
    localparam logic [2:0] S_ADD   = 3'd3;
    localparam logic [2:0] S_WBACK = 3'd4;

    // buffer as 16 words with byte enables; one read port
    logic [31:0] r_buf [md5_pkg::WordCount];
    logic [31:0] r_buf_q;
    logic [3:0]  buf_raddr;

    // chaining value registers (4 words, each read at own place or by index)
    logic [31:0] r_chain [4];

    logic [2:0]  r_state, n_state;
    logic [5:0]  r_step, n_step;
    logic [31:0] r_a, r_b, r_c, r_d;
    logic [1:0]  r_wb;

    logic [31:0] f_val, sum, rot;
    logic [4:0]  sh;

    // write one byte lane of the buffer
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            case (i_wr_addr[1:0])
                2'd0:    r_buf[i_wr_addr[5:2]][7:0]   <= i_wr_byte;
                2'd1:    r_buf[i_wr_addr[5:2]][15:8]  <= i_wr_byte;
                2'd2:    r_buf[i_wr_addr[5:2]][23:16] <= i_wr_byte;
                default: r_buf[i_wr_addr[5:2]][31:24] <= i_wr_byte;
            endcase
        end
        r_buf_q <= r_buf[buf_raddr];
    end

    // prefetch the word for the next step
    always_comb begin
        buf_raddr = md5_pkg::msg_index(r_step);
        if (r_state == S_STEP) begin
            buf_raddr = md5_pkg::msg_index(6'(r_step + 6'd1));
        end
    end

    always_comb begin
        case (r_step[5:4])
            2'd0:    f_val = (r_b & r_c) | (~r_b & r_d);
            2'd1:    f_val = (r_b & r_d) | (r_c & ~r_d);
            2'd2:    f_val = r_b ^ r_c ^ r_d;
            default: f_val = r_c ^ (r_b | ~r_d);
        endcase
        sum = r_a + f_val + md5_pkg::round_const(r_step) + r_buf_q;
        sh  = md5_pkg::rot_amount(r_step);
        rot = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        case (r_state)
            S_IDLE:  if (i_req.start) n_state = S_LOAD;
            S_LOAD:  begin n_state = S_STEP; n_step = 6'd0; end
            S_STEP:  begin
                n_step = 6'(r_step + 6'd1);
                if (r_step == 6'(md5_pkg::StepCount - 1)) n_state = S_ADD;
            end
            S_ADD:   n_state = S_WBACK;
            S_WBACK: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= 6'd0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    // working variables: load, step, then add back into the chain
    always_ff @(posedge i_clk) begin
        r_wb <= 2'd0;
        if (r_state == S_LOAD) begin
            r_a <= r_chain[0]; r_b <= r_chain[1];
            r_c <= r_chain[2]; r_d <= r_chain[3];
        end else if (r_state == S_STEP) begin
            r_a <= r_d; r_d <= r_c; r_c <= r_b;
            r_b <= r_b + rot;
        end else if (r_state == S_ADD) begin
            r_a <= r_a + r_chain[0]; r_b <= r_b + r_chain[1];
            r_c <= r_c + r_chain[2]; r_d <= r_d + r_chain[3];
        end
    end

    // chaining value update and reinit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_chain_init) begin
            r_chain[0] <= md5_pkg::INIT_A; r_chain[1] <= md5_pkg::INIT_B;
            r_chain[2] <= md5_pkg::INIT_C; r_chain[3] <= md5_pkg::INIT_D;
        end else if (r_state == S_WBACK) begin
            r_chain[0] <= r_a; r_chain[1] <= r_b;
            r_chain[2] <= r_c; r_chain[3] <= r_d;
        end
    end

    assign o_chain_word = r_chain[i_rd_idx];
    assign o_sts.busy   = (r_state != S_IDLE) || (r_wb != 2'd0);
    assign o_sts.done   = (r_state == S_WBACK);

endmodule

// ===== rtl/md5_message_digest.sv =====
// ----------------------------------------------------------------------------
// md5_message_digest
// MD5 digest of a byte stream: append bytes, finish to read four words.
// ----------------------------------------------------------------------------
//  channel | dir | payload                              | accepted when
//  i_in    | in  | op, data_byte                        | valid && ready
//  o_out   | out | digest_word, word_index, last_word   | valid && ready
//
//  An append writes one byte; the 64th byte of a block then holds the input
//  through load, 64 single-step rounds (one MD5 step per cycle), add and
//  write back.
//  A finish writes the rest of the padding one byte per cycle, runs each block,
//  then presents four words, one per output request.
//  Reset restores the initial chaining value; output stalls hold the word.
module md5_message_digest (
    input  logic        i_clk,
    input  logic        i_rst_n,
    md5_stream_if.sink   i_in,
    md5_stream_if.source o_out
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RUN  = 3'd1;
    localparam logic [2:0] S_PAD  = 3'd2;
    localparam logic [2:0] S_FRUN = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    md5_pkg::t_in_item  in_item;
    md5_pkg::t_out_item out_item;
    md5_pkg::t_core_req core_req;
    md5_pkg::t_core_sts core_sts;

    logic [2:0]  r_state, n_state;
    logic [5:0]  r_fill;
    logic [md5_pkg::CountWidth-1:0] r_count;
    logic [63:0] r_bits;
    logic        r_last_blk;  // block being padded carries the length
    logic [1:0]  r_widx;
    logic        wr_en;
    logic [5:0]  wr_addr;
    logic [7:0]  wr_byte, pad_byte;
    logic        accept, chain_init;
    logic [31:0] chain_word;

    assign in_item = md5_pkg::t_in_item'(i_in.payload);
    assign accept  = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);

    // padding byte at the current position
    always_comb begin
        pad_byte = 8'h00;
        if (r_fill >= 6'(md5_pkg::PadLimit) && r_last_blk) begin
            pad_byte = r_bits[{r_fill[2:0], 3'b000} +: 8];
        end
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_fill;
        wr_byte = in_item.data_byte;
        if (accept) begin
            wr_en = 1'b1;
            if (in_item.op == md5_pkg::OP_FINISH) wr_byte = md5_pkg::PAD_BYTE;
        end else if (r_state == S_PAD) begin
            wr_en   = 1'b1;
            wr_byte = pad_byte;
        end
    end

    // start a block whenever its last byte is written
    assign core_req.start = (accept && r_fill == 6'd63)
                         || (r_state == S_PAD && r_fill == 6'd63);
    assign chain_init = (r_state == S_EMIT) && o_out.ready && r_widx == 2'd3;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (accept) begin
                if (in_item.op == md5_pkg::OP_FINISH) begin
                    n_state = (r_fill == 6'd63) ? S_FRUN : S_PAD;
                end else if (r_fill == 6'd63) begin
                    n_state = S_RUN;
                end
            end
            S_RUN:  if (core_sts.done) n_state = S_IDLE;
            S_PAD:  if (r_fill == 6'd63) n_state = S_FRUN;
            S_FRUN: if (core_sts.done) n_state = r_last_blk ? S_EMIT : S_PAD;
            S_EMIT: if (o_out.ready && r_widx == 2'd3) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // advance fill position, count and padding flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_fill     <= 6'd0;
            r_count    <= '0;
            r_last_blk <= 1'b0;
            r_widx     <= 2'd0;
        end else begin
            r_state <= n_state;
            if (wr_en) r_fill <= 6'(r_fill + 6'd1);
            if (accept && in_item.op == md5_pkg::OP_APPEND) begin
                r_count <= r_count + 1'b1;
            end
            if (accept && in_item.op == md5_pkg::OP_FINISH) begin
                r_bits     <= {r_count, 3'b000};
                r_last_blk <= (r_fill < 6'(md5_pkg::PadLimit));
            end
            if (r_state == S_FRUN && core_sts.done) r_last_blk <= 1'b1;
            if (r_state == S_EMIT && o_out.ready) r_widx <= 2'(r_widx + 2'd1);
            if (chain_init) begin
                r_count <= '0;
                r_fill  <= 6'd0;
            end
        end
    end

    md5_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_wr_en      (wr_en),
        .i_wr_addr    (wr_addr),
        .i_wr_byte    (wr_byte),
        .i_req        (core_req),
        .i_chain_init (chain_init),
        .i_rd_idx     (r_widx),
        .o_chain_word (chain_word),
        .o_sts        (core_sts)
    );

    assign out_item.digest_word = chain_word;
    assign out_item.word_index  = r_widx;
    assign out_item.last_word   = (r_widx == 2'd3);
    assign o_out.valid   = (r_state == S_EMIT);
    assign o_out.payload = out_item;

endmodule

// ===== rtl/md5_checker.sv =====
// ----------------------------------------------------------------------------
// md5_checker
// Port-level checks on the digest engine, bound to the top level.
// ----------------------------------------------------------------------------
module md5_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [34:0] i_out_payload
);

    // no new request is taken while digest words are pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready) else $error("input taken during emit");

    // last flag matches word index three
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_payload[0] == (i_out_payload[2:1] == 2'd3)))
        else $error("last flag mismatch");

    // stalled output holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_payload))
        else $error("output dropped");

    // word index advances by one after each delivered non-last word
    a_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_out_payload[0] |=>
        i_out_valid && i_out_payload[2:1] == 2'($past(i_out_payload[2:1]) + 2'd1))
        else $error("word order broken");

endmodule

bind md5_message_digest md5_checker u_md5_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_payload(o_out.payload)
);

// ===== tb/md5_message_digest_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// md5_message_digest_test
// Streams byte messages into the MD5 engine, computes each digest in a local
// model and compares the four digest words of every finish in order.
// ----------------------------------------------------------------------------

class md5_digest_board;
    logic [31:0] chain[4];
    logic [7:0]  blk[64];
    int unsigned fill;
    logic [60:0] nbytes;
    md5_pkg::t_out_item pending[$];
    int unsigned errors;

    function new();
        errors = 0;
        restart();
    endfunction

    function void restart();
        chain[0] = md5_pkg::INIT_A;
        chain[1] = md5_pkg::INIT_B;
        chain[2] = md5_pkg::INIT_C;
        chain[3] = md5_pkg::INIT_D;
        fill = 0;
        nbytes = '0;
    endfunction

    function void compress();
        logic [31:0] m[16];
        logic [31:0] a, b, c, d, f, t, k, sum;
        int unsigned g, s, r;
        int unsigned rots[16] = '{7, 12, 17, 22, 5, 9, 14, 20,
                                  4, 11, 16, 23, 6, 10, 15, 21};
        for (int i = 0; i < 16; i++)
            m[i] = {blk[4*i+3], blk[4*i+2], blk[4*i+1], blk[4*i]};
        a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
        for (int i = 0; i < 64; i++) begin
            r = i / 16;
            case (r)
                0: begin f = (b & c) | (~b & d); g = i; end
                1: begin f = (b & d) | (c & ~d); g = (1 + 5*i) % 16; end
                2: begin f = b ^ c ^ d; g = (5 + 3*i) % 16; end
                default: begin f = c ^ (b | ~d); g = (7*i) % 16; end
            endcase
            // sine table entry: floor(abs(sin(i+1)) * 2^32)
            k = 32'(longint'($floor(($sin(i + 1) < 0 ? -$sin(i + 1) : $sin(i + 1))
                * 4294967296.0)));
            s = rots[r*4 + i%4];
            sum = a + f + k + m[g];
            t = d; d = c; c = b;
            b = b + ((sum << s) | (sum >> (32 - s)));
            a = t;
        end
        chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
    endfunction

    // note an accepted request; a finish queues the four digest words
    function void note_request(md5_pkg::t_in_item it);
        logic [63:0] bits;
        md5_pkg::t_out_item w;
        if (it.op == md5_pkg::OP_APPEND) begin
            blk[fill] = it.data_byte;
            fill = (fill + 1) % 64;
            nbytes = nbytes + 1;
            if (fill == 0) compress();
            return;
        end
        bits = {nbytes, 3'b000};
        blk[fill] = md5_pkg::PAD_BYTE;
        fill++;
        if (fill > md5_pkg::PadLimit) begin
            while (fill < 64) blk[fill++] = 8'h00;
            compress();
            fill = 0;
        end
        while (fill < md5_pkg::PadLimit) blk[fill++] = 8'h00;
        for (int i = 0; i < 8; i++) blk[56 + i] = bits[8*i +: 8];
        compress();
        for (int i = 0; i < 4; i++) begin
            w.digest_word = chain[i];
            w.word_index = 2'(i);
            w.last_word = (i == 3);
            pending.push_back(w);
        end
        restart();
    endfunction

    function void check_word(md5_pkg::t_out_item got);
        md5_pkg::t_out_item exp;
        if (pending.size() == 0) begin
            $display("%0t: unexpected digest word %h", $time, got);
            errors++;
            return;
        end
        exp = pending.pop_front();
        if (got.digest_word !== exp.digest_word) begin
            $display("%0t: digest_word expected %h actual %h", $time,
                     exp.digest_word, got.digest_word);
            errors++;
        end
        if (got.word_index !== exp.word_index) begin
            $display("%0t: word_index expected %0d actual %0d", $time,
                     exp.word_index, got.word_index);
            errors++;
        end
        if (got.last_word !== exp.last_word) begin
            $display("%0t: last_word expected %b actual %b", $time,
                     exp.last_word, got.last_word);
            errors++;
        end
    endfunction
endclass

module md5_message_digest_test;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    bit   calm = 1'b0;
    md5_digest_board board = new();

    md5_stream_if #(.Width(9))  in_ch();
    md5_stream_if #(.Width(35)) out_ch();

    md5_message_digest i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        in_ch.valid = 1'b0;
        in_ch.payload = '0;
        out_ch.ready = 1'b0;
    end

    // sample accepted requests on both channels
    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready)
            board.note_request(md5_pkg::t_in_item'(in_ch.payload));
        if (i_rst_n && out_ch.valid && out_ch.ready)
            board.check_word(md5_pkg::t_out_item'(out_ch.payload));
    end

    // drive ready with random stalls
    always @(negedge i_clk) begin
        out_ch.ready <= i_rst_n && (calm || $urandom_range(99) >= 10);
    end

    // hold valid high after a request; idle cycles drop it
    task automatic send(logic op, logic [7:0] data);
        while ($urandom_range(99) < 10 && !calm) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.payload <= {op, data};
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_message(int unsigned len, int unsigned fixed);
        for (int unsigned i = 0; i < len; i++)
            send(md5_pkg::OP_APPEND, fixed < 256 ? 8'(fixed) : 8'($urandom));
        send(md5_pkg::OP_FINISH, 8'($urandom));
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (board.pending.size() != 0) @(negedge i_clk);
    endtask

    initial begin
        int unsigned sent, len;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        // directed: empty message, extremes, padding boundaries
        send_message(0, 0);
        send_message(1, 8'h00);
        send_message(1, 8'hff);
        send_message(3, 256);
        send_message(55, 256);
        drain();
        send_message(56, 256);
        send_message(64, 256);
        send_message(63, 8'hff);
        // random messages, mostly short, one long stretch without stalls
        sent = 0;
        while (sent < 150) begin
            calm = (sent > 40 && sent < 110);
            len = ($urandom_range(9) == 0) ? $urandom_range(130)
                                            : $urandom_range(20);
            send_message(len, 256);
            sent += len + 1;
        end
        calm = 1'b0;
        drain();
        repeat (200) @(posedge i_clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #20ms;
        $display("Verification failed");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/md5_pkg.sv
rtl/md5_stream_if.sv
rtl/md5_core.sv
rtl/md5_message_digest.sv
rtl/md5_checker.sv
tb/md5_message_digest_test.sv
